@@ design/tun_pkg.sv @@
package tun_pkg;

   localparam int COORD_W    = 16;
   localparam int EDGE_W     = 17;
   localparam int PROD_W     = 34;
   localparam int MAG_W      = 34;
   localparam int HALF_W     = 17;
   localparam int SQ_W       = 68;
   localparam int ROOT_W     = 34;
   localparam int REM_W      = 37;
   localparam int FRAC_BITS  = 14;
   localparam int QUO_W      = 15;
   localparam int DIVD_W     = MAG_W + FRAC_BITS;
   localparam int NORM_W     = 16;
   localparam int ISQ_STAGES = 17;
   localparam int DIV_STAGES = 8;
   localparam int LANE_LAT   = DIV_STAGES + 1;
   localparam int FRONT_LAT  = 5;
   localparam int LATENCY    = FRONT_LAT + ISQ_STAGES + LANE_LAT;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic                     degenerate;
   } rsp_type;

endpackage

@@ design/triangle_unit_normal.sv @@
// Unit face normal of one triangle: N = (A-B) x (B-C), scaled by the floor
// square root of its exact squared length to signed Q1.14 (16384 is one),
// truncated toward zero; a zero cross product gives the zero vector with
// degenerate set. Fully pipelined: one triangle per cycle while rsp does not
// stall, passing through 5 front stages for the cross product and squared
// length, 17 square-root stages at two root bits each, 8 divider stages at
// two quotient bits each but the last at one, and the output register.
// A stall on rsp freezes the whole pipeline and req_ready drops with it.
module triangle_unit_normal import tun_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic [2:0]              neg;
      logic [2:0][MAG_W-1:0]   mag;
   } side_type;

   typedef struct packed {
      logic [SQ_W-1:0]   s;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic              deg;
      side_type          side;
   } sq_type;

   function automatic sq_type isq_step(sq_type x);
      sq_type           y;
      logic [REM_W-1:0] r;
      logic [ROOT_W+1:0] t;
      y = x;
      r = {x.rem[REM_W-3:0], x.s[SQ_W-1:SQ_W-2]};
      t = {x.root, 2'b01};
      y.s = {x.s[SQ_W-3:0], 2'b00};
      if (r >= {1'b0, t}) begin
         y.rem  = r - {1'b0, t};
         y.root = {x.root[ROOT_W-2:0], 1'b1};
      end else begin
         y.rem  = r;
         y.root = {x.root[ROOT_W-2:0], 1'b0};
      end
      return y;
   endfunction

   logic                     en;
   logic [LATENCY-1:0]       valid_ff;
   logic signed [EDGE_W-1:0] e_ff [6];
   logic signed [PROD_W-1:0] p_ff [6];
   side_type                 side3_ff, side4_ff, side5_ff;
   logic [2:0][PROD_W-1:0]   hh_ff, hl_ff, ll_ff;
   logic [2:0][SQ_W-1:0]     sq_ff;
   sq_type                   root_in;
   sq_type                   isq_ff [ISQ_STAGES];
   side_type                 side3_in;
   logic [LANE_LAT-1:0]      deg_ff;
   logic [ROOT_W-1:0]        len;
   logic [SQ_W-1:0]          sum_in;
   logic signed [NORM_W-1:0] norm [3];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LATENCY-2:0], req_valid};
      end
   end

   always_comb begin
      logic signed [PROD_W:0] n [3];
      n[0] = {p_ff[0][PROD_W-1], p_ff[0]} - {p_ff[1][PROD_W-1], p_ff[1]};
      n[1] = {p_ff[2][PROD_W-1], p_ff[2]} - {p_ff[3][PROD_W-1], p_ff[3]};
      n[2] = {p_ff[4][PROD_W-1], p_ff[4]} - {p_ff[5][PROD_W-1], p_ff[5]};
      for (int k = 0; k < 3; k++) begin
         side3_in.neg[k] = n[k][PROD_W];
         side3_in.mag[k] = n[k][PROD_W] ? MAG_W'(-n[k]) : MAG_W'(n[k]);
      end
   end

   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0] <= EDGE_W'(req_data.a_x) - EDGE_W'(req_data.b_x);
         e_ff[1] <= EDGE_W'(req_data.a_y) - EDGE_W'(req_data.b_y);
         e_ff[2] <= EDGE_W'(req_data.a_z) - EDGE_W'(req_data.b_z);
         e_ff[3] <= EDGE_W'(req_data.b_x) - EDGE_W'(req_data.c_x);
         e_ff[4] <= EDGE_W'(req_data.b_y) - EDGE_W'(req_data.c_y);
         e_ff[5] <= EDGE_W'(req_data.b_z) - EDGE_W'(req_data.c_z);
         p_ff[0] <= e_ff[1] * e_ff[5];
         p_ff[1] <= e_ff[2] * e_ff[4];
         p_ff[2] <= e_ff[2] * e_ff[3];
         p_ff[3] <= e_ff[0] * e_ff[5];
         p_ff[4] <= e_ff[0] * e_ff[4];
         p_ff[5] <= e_ff[1] * e_ff[3];
         side3_ff <= side3_in;
         for (int k = 0; k < 3; k++) begin
            hh_ff[k] <= side3_ff.mag[k][MAG_W-1:HALF_W] * side3_ff.mag[k][MAG_W-1:HALF_W];
            hl_ff[k] <= side3_ff.mag[k][MAG_W-1:HALF_W] * side3_ff.mag[k][HALF_W-1:0];
            ll_ff[k] <= side3_ff.mag[k][HALF_W-1:0] * side3_ff.mag[k][HALF_W-1:0];
            sq_ff[k] <= {hh_ff[k], {PROD_W{1'b0}}}
                      + (SQ_W'(hl_ff[k]) << (HALF_W + 1))
                      + SQ_W'(ll_ff[k]);
         end
         side4_ff <= side3_ff;
         side5_ff <= side4_ff;
      end
   end

   always_comb begin
      root_in.s    = sum_in;
      root_in.rem  = '0;
      root_in.root = '0;
      root_in.deg  = (sum_in == '0);
      root_in.side = side5_ff;
   end

   for (genvar s = 0; s < ISQ_STAGES; s++) begin : g_isq
      sq_type src;
      if (s == 0) begin : g_first
         assign src = root_in;
      end else begin : g_rest
         assign src = isq_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (en) isq_ff[s] <= isq_step(isq_step(src));
      end
   end

   assign len = isq_ff[ISQ_STAGES-1].deg ? ROOT_W'(1) : isq_ff[ISQ_STAGES-1].root;

   always_ff @(posedge clock) begin
      if (en) deg_ff <= {deg_ff[LANE_LAT-2:0], isq_ff[ISQ_STAGES-1].deg};
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      tun_div_lane u_lane (
         .clock    (clock),
         .en       (en),
         .in_mag   (isq_ff[ISQ_STAGES-1].side.mag[k]),
         .in_len   (len),
         .in_neg   (isq_ff[ISQ_STAGES-1].side.neg[k]),
         .out_norm (norm[k])
      );
   end

   always_comb begin
      rsp_data.normal_x   = norm[0];
      rsp_data.normal_y   = norm[1];
      rsp_data.normal_z   = norm[2];
      rsp_data.degenerate = deg_ff[LANE_LAT-1];
   end

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.normal_x == 0 && rsp_data.normal_y == 0 && rsp_data.normal_z == 0)
      else $error("degenerate result with nonzero normal");

   a_nondegen_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |->
         rsp_data.normal_x != 0 || rsp_data.normal_y != 0 || rsp_data.normal_z != 0)
      else $error("zero normal without degenerate flag");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.normal_x <= 16'sd16384 && rsp_data.normal_x >= -16'sd16384
                 && rsp_data.normal_y <= 16'sd16384 && rsp_data.normal_y >= -16'sd16384
                 && rsp_data.normal_z <= 16'sd16384 && rsp_data.normal_z >= -16'sd16384)
      else $error("normal component beyond one");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved during stall");

endmodule

@@ design/tun_div_lane.sv @@
module tun_div_lane import tun_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic [MAG_W-1:0]         in_mag,
   input  logic [ROOT_W-1:0]        in_len,
   input  logic                     in_neg,
   output logic signed [NORM_W-1:0] out_norm
);

   typedef struct packed {
      logic [DIVD_W-1:0] rem;
      logic [QUO_W-1:0]  q;
      logic [ROOT_W-1:0] len;
      logic              neg;
   } dv_type;

   function automatic dv_type dv_step(dv_type x, int i);
      dv_type          y;
      logic [DIVD_W:0] d;
      y = x;
      d = {{(DIVD_W+1-ROOT_W){1'b0}}, x.len} << i;
      if ({1'b0, x.rem} >= d) begin
         y.rem = x.rem - d[DIVD_W-1:0];
         y.q   = x.q | (QUO_W'(1) << i);
      end
      return y;
   endfunction

   dv_type                   st_ff [DIV_STAGES];
   dv_type                   init_in;
   logic signed [NORM_W-1:0] norm_ff;
   logic signed [NORM_W-1:0] norm_in;

   always_comb begin
      init_in.rem = {in_mag, {FRAC_BITS{1'b0}}};
      init_in.q   = '0;
      init_in.len = in_len;
      init_in.neg = in_neg;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      dv_type src;
      dv_type mid;
      dv_type nxt;
      if (s == 0) begin : g_first
         assign src = init_in;
      end else begin : g_rest
         assign src = st_ff[s-1];
      end
      assign mid = dv_step(src, QUO_W - 1 - 2*s);
      if (QUO_W - 2 - 2*s >= 0) begin : g_two
         assign nxt = dv_step(mid, QUO_W - 2 - 2*s);
      end else begin : g_one
         assign nxt = mid;
      end
      always_ff @(posedge clock) begin
         if (en) st_ff[s] <= nxt;
      end
   end

   always_comb begin
      norm_in = $signed({1'b0, st_ff[DIV_STAGES-1].q});
      if (st_ff[DIV_STAGES-1].neg) norm_in = -norm_in;
   end

   always_ff @(posedge clock) begin
      if (en) norm_ff <= norm_in;
   end

   assign out_norm = norm_ff;

endmodule
